@@ design/lcd4_pkg.sv @@
// Shared types, codes and constants for the 4-bit character LCD interface.
package lcd4_pkg;

    // Action codes carried by one request
    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_CMD    = 2'd1,
        ACT_DATA   = 2'd2,
        ACT_CURSOR = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE_PULSE   = 2'd0,
        CFG_COMMAND_SETTLE = 2'd1,
        CFG_POWERUP_WAIT   = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    localparam logic [3:0] ENABLE_PULSE_RST   = 4'd1;
    localparam logic [3:0] COMMAND_SETTLE_RST = 4'd2;
    localparam logic [7:0] POWERUP_WAIT_RST   = 8'd40;

    // Phase counter: init runs 25 phases, a byte action 4
    localparam int PHASE_W = 5;
    localparam logic [PHASE_W-1:0] INIT_LAST_PHASE = 5'd24;
    localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE = 5'd3;

    // Controller to datapath
    typedef struct packed {
        logic               capture;  // latch the incoming request
        logic               load;     // load the output register with a phase
        logic [PHASE_W-1:0] phase;    // phase index within the action
        logic               last;     // final phase of the action
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [PHASE_W-1:0] last_idx; // index of the final phase of the held action
    } t_dp_status;

endpackage

@@ design/lcd4_ctrl.sv @@
// Controller state machine: request handshake, phase sequencing, output valid.
module lcd4_ctrl
    import lcd4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_out_valid, n_out_valid;
    logic               capture, advance, at_last;

    assign capture = (r_state == S_IDLE) && i_valid;
    assign advance = (r_state == S_RUN) && (!r_out_valid || i_ready);
    assign at_last = (r_phase == i_status.last_idx);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_RUN;
                    n_phase = '0;
                end
            end
            S_RUN: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    if (at_last) begin
                        n_state = S_IDLE;
                        n_phase = '0;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_phase = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_cmd.capture = capture;
    assign o_cmd.load    = advance;
    assign o_cmd.phase   = r_phase;
    assign o_cmd.last    = at_last;

    // Counter rests at zero between actions
    a_idle_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_phase == '0))
        else $error("phase counter not cleared while idle");

    // Counter never runs past the longest action
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase <= INIT_LAST_PHASE))
        else $error("phase counter out of range");

    // A captured request always starts a run
    a_capture_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> (r_state == S_RUN) && (r_phase == '0))
        else $error("capture did not start a run");

    // The final phase returns the controller to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && at_last) |=> (r_state == S_IDLE) && r_out_valid)
        else $error("final phase did not end the run");

endmodule

@@ design/lcd4_datapath.sv @@
// Datapath: configuration registers, request latch, phase decode, pin history, output register.
module lcd4_datapath
    import lcd4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl_cmd   i_cmd,
    output t_dp_status o_status,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic [1:0] i_action,
    input  logic [7:0] i_byte_value,
    input  logic       i_cursor_row,
    input  logic [5:0] i_cursor_col,
    output logic       o_reg_select,
    output logic       o_enable_pin,
    output logic [3:0] o_bus_nibble,
    output logic [7:0] o_hold_ms,
    output logic       o_last_phase
);

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;
    localparam logic [7:0] GAP_LONG  = 8'd5;
    localparam logic [7:0] GAP_SHORT = 8'd1;
    localparam logic [7:0] CURSOR_CMD = 8'h80;
    localparam logic [PHASE_W-1:0] INIT_BYTE_BASE = 5'd9;

    // Init command bytes in order: function set, display on, entry mode, clear
    function automatic logic [7:0] init_byte(input logic [1:0] j);
        case (j)
            2'd0:    init_byte = 8'h28;
            2'd1:    init_byte = 8'h0C;
            2'd2:    init_byte = 8'h06;
            default: init_byte = 8'h01;
        endcase
    endfunction

    logic [3:0] r_enable_pulse, r_command_settle;
    logic [7:0] r_powerup_wait;
    logic       r_is_init, r_rs;
    logic [7:0] r_byte;
    logic       r_last_rs;
    logic [3:0] r_last_nib;

    logic       r_out_rs, r_out_en, r_out_last;
    logic [3:0] r_out_nib;
    logic [7:0] r_out_hold;

    logic       n_rs, n_en;
    logic [3:0] n_nib;
    logic [7:0] n_hold;
    logic [7:0] cursor_addr;

    // Configuration writes, index three dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_pulse   <= ENABLE_PULSE_RST;
            r_command_settle <= COMMAND_SETTLE_RST;
            r_powerup_wait   <= POWERUP_WAIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ENABLE_PULSE:   r_enable_pulse   <= i_cfg_data[3:0];
                CFG_COMMAND_SETTLE: r_command_settle <= i_cfg_data[3:0];
                CFG_POWERUP_WAIT:   r_powerup_wait   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cursor_addr = {1'b0, i_cursor_row, 6'b0} + {2'b0, i_cursor_col};

    // Request latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_init <= 1'b0;
        end else if (i_cmd.capture) begin
            r_is_init <= (t_action'(i_action) == ACT_INIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rs <= (t_action'(i_action) == ACT_DATA);
            case (t_action'(i_action))
                ACT_CURSOR: r_byte <= CURSOR_CMD | cursor_addr;
                default:    r_byte <= i_byte_value;
            endcase
        end
    end

    assign o_status.last_idx = r_is_init ? INIT_LAST_PHASE : BYTE_LAST_PHASE;

    // Phase decode
    always_comb begin
        logic [PHASE_W-1:0] q;
        logic [1:0]         sub;
        logic [7:0]         b;
        logic [7:0]         extra;
        logic [7:0]         pulse;
        q     = '0;
        sub   = i_cmd.phase[1:0];
        b     = r_byte;
        extra = '0;
        pulse = {4'b0, r_enable_pulse};
        n_rs  = r_rs;
        n_en  = 1'b0;
        n_nib = '0;
        n_hold = pulse;
        if (r_is_init && i_cmd.phase == '0) begin
            // power-up wait shows the previous RS and data levels
            n_rs   = r_last_rs;
            n_nib  = r_last_nib;
            n_hold = r_powerup_wait;
        end else if (r_is_init && i_cmd.phase < INIT_BYTE_BASE) begin
            q     = i_cmd.phase - 1'b1;
            n_rs  = 1'b0;
            n_en  = !q[0];
            n_nib = (q[2:1] == 2'd3) ? NIB_4BIT : NIB_WAKE;
            if (q[0]) begin
                case (q[2:1])
                    2'd0, 2'd1: n_hold = pulse + GAP_LONG;
                    2'd2:       n_hold = pulse + GAP_SHORT;
                    default:    n_hold = pulse;
                endcase
            end
        end else begin
            if (r_is_init) begin
                q     = i_cmd.phase - INIT_BYTE_BASE;
                sub   = q[1:0];
                b     = init_byte(q[3:2]);
                n_rs  = 1'b0;
                extra = (q[3:2] == 2'd3) ? GAP_LONG : 8'd0;
            end
            n_en  = !sub[0];
            n_nib = sub[1] ? b[3:0] : b[7:4];
            if (sub == 2'd3) begin
                n_hold = pulse + {4'b0, r_command_settle} + extra;
            end
        end
    end

    // Pin history for the power-up phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rs  <= 1'b0;
            r_last_nib <= '0;
        end else if (i_cmd.load) begin
            r_last_rs  <= n_rs;
            r_last_nib <= n_nib;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_rs   <= n_rs;
            r_out_en   <= n_en;
            r_out_nib  <= n_nib;
            r_out_hold <= n_hold;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_reg_select = r_out_rs;
    assign o_enable_pin = r_out_en;
    assign o_bus_nibble = r_out_nib;
    assign o_hold_ms    = r_out_hold;
    assign o_last_phase = r_out_last;

endmodule

@@ design/char_lcd_4bit_interface.sv @@
// Top level of the 4-bit character LCD interface: controller plus datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  request  | i_valid / o_ready        | i_action, i_byte_value, i_cursor_row, i_cursor_col
//  phase    | o_valid / i_ready        | o_reg_select, o_enable_pin, o_bus_nibble,
//           |                          | o_hold_ms, o_last_phase
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A request is taken while the controller is idle; its phases are then loaded in
// order, each as soon as the output register is empty or being taken: 4 phases
// for a command, data or cursor request, 25 for init. The phase counter in the
// controller sets the number of phases.
// Synchronous active-low reset restores the timing registers to 1, 2 and 40 ms,
// clears the remembered pin levels to all low and drops the phase valid.
// A stalled phase holds in the output register; the next request is taken as
// soon as the final phase has been loaded, even while it still waits.
module char_lcd_4bit_interface
    import lcd4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_byte_value,
    input  logic       i_cursor_row,
    input  logic [5:0] i_cursor_col,
    // phase channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_reg_select,
    output logic       o_enable_pin,
    output logic [3:0] o_bus_nibble,
    output logic [7:0] o_hold_ms,
    output logic       o_last_phase,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    // Configuration writes are always accepted
    assign o_cfg_ready = 1'b1;

    // Sequence requests into phases and own the output valid
    lcd4_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Decode each phase into pin levels and hold time
    lcd4_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_cursor_row (i_cursor_row),
        .i_cursor_col (i_cursor_col),
        .o_reg_select (o_reg_select),
        .o_enable_pin (o_enable_pin),
        .o_bus_nibble (o_bus_nibble),
        .o_hold_ms    (o_hold_ms),
        .o_last_phase (o_last_phase)
    );

endmodule

@@ bench/char_lcd_4bit_interface_tb.sv @@
// Self-checking testbench for the 4-bit character LCD interface: pin phase prediction and checking.
module char_lcd_4bit_interface_tb
    import lcd4_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    // Longest stretch with no handshake on any channel before the run is called hung.
    // Receiver stalls and request pauses are random but bounded, so this limit is generous.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to let pass after the last phase before touching the timing registers
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 12;

    // Display controller protocol constants
    localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;
    localparam logic [7:0] FUNC_SET_4BIT   = 8'h28;
    localparam logic [7:0] DISPLAY_ON      = 8'h0C;
    localparam logic [7:0] ENTRY_MODE_INC  = 8'h06;
    localparam logic [7:0] CLEAR_DISPLAY   = 8'h01;
    localparam logic [7:0] ROW1_BASE       = 8'h40;
    localparam logic [7:0] SET_DDRAM_ADDR  = 8'h80;
    localparam int WAKE_GAP_LONG_MS  = 5;
    localparam int WAKE_GAP_SHORT_MS = 1;
    localparam int CLEAR_EXTRA_MS    = 5;

    typedef struct packed {
        logic       reg_select;
        logic       enable_pin;
        logic [3:0] bus_nibble;
        logic [7:0] hold_ms;
        logic       last_phase;
    } t_pin_phase;

    // Predicts the pin phases of every accepted request and checks them in order
    class lcd_pin_scoreboard;
        logic [3:0] enable_pulse_ms;
        logic [3:0] command_settle_ms;
        logic [7:0] powerup_wait_ms;
        logic       rs_level;
        logic [3:0] nibble_level;
        t_pin_phase pending_phases[$];
        t_pin_phase action_phases[$];
        int         errors;

        function new();
            enable_pulse_ms   = ENABLE_PULSE_RST;
            command_settle_ms = COMMAND_SETTLE_RST;
            powerup_wait_ms   = POWERUP_WAIT_RST;
            rs_level          = 1'b0;
            nibble_level      = 4'h0;
            errors            = 0;
        endfunction

        function void write_timing_reg(t_cfg_index idx, logic [7:0] data);
            case (idx)
                CFG_ENABLE_PULSE:   enable_pulse_ms   = data[3:0];
                CFG_COMMAND_SETTLE: command_settle_ms = data[3:0];
                CFG_POWERUP_WAIT:   powerup_wait_ms   = data;
                default: ;
            endcase
        endfunction

        function void add_phase(logic rs, logic en, logic [3:0] nib, int hold);
            t_pin_phase p;
            p.reg_select = rs;
            p.enable_pin = en;
            p.bus_nibble = nib;
            p.hold_ms    = (hold > 255) ? 8'd255 : 8'(hold);
            p.last_phase = 1'b0;
            action_phases.push_back(p);
            rs_level     = rs;
            nibble_level = nib;
        endfunction

        function void add_nibble(logic rs, logic [3:0] nib, int extra_ms);
            add_phase(rs, 1'b1, nib, int'(enable_pulse_ms));
            add_phase(rs, 1'b0, nib, int'(enable_pulse_ms) + extra_ms);
        endfunction

        function void add_byte(logic rs, logic [7:0] value, int extra_ms);
            add_nibble(rs, value[7:4], 0);
            add_nibble(rs, value[3:0], int'(command_settle_ms) + extra_ms);
        endfunction

        function void note_request(t_action act, logic [7:0] value, logic row, logic [5:0] col);
            logic [7:0] addr;
            t_pin_phase p;
            action_phases.delete();
            case (act)
                ACT_INIT: begin
                    // power-up wait keeps the previous RS and data levels, EN low
                    add_phase(rs_level, 1'b0, nibble_level, int'(powerup_wait_ms));
                    add_nibble(1'b0, WAKE_NIBBLE, WAKE_GAP_LONG_MS);
                    add_nibble(1'b0, WAKE_NIBBLE, WAKE_GAP_LONG_MS);
                    add_nibble(1'b0, WAKE_NIBBLE, WAKE_GAP_SHORT_MS);
                    add_nibble(1'b0, BUS_4BIT_NIBBLE, 0);
                    add_byte(1'b0, FUNC_SET_4BIT, 0);
                    add_byte(1'b0, DISPLAY_ON, 0);
                    add_byte(1'b0, ENTRY_MODE_INC, 0);
                    add_byte(1'b0, CLEAR_DISPLAY, CLEAR_EXTRA_MS);
                end
                ACT_CMD:  add_byte(1'b0, value, 0);
                ACT_DATA: add_byte(1'b1, value, 0);
                default: begin
                    addr = (row ? ROW1_BASE : 8'h00) + {2'b00, col};
                    add_byte(1'b0, SET_DDRAM_ADDR | addr, 0);
                end
            endcase
            foreach (action_phases[i]) begin
                p = action_phases[i];
                p.last_phase = (i == action_phases.size() - 1);
                pending_phases.push_back(p);
            end
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $display("%0t: phase %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_phase(t_pin_phase got);
            t_pin_phase want;
            if (pending_phases.size() == 0) begin
                $display("%0t: unexpected phase: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_phases.pop_front();
            compare_field("reg_select", want.reg_select, got.reg_select);
            compare_field("enable_pin", want.enable_pin, got.enable_pin);
            compare_field("bus_nibble", want.bus_nibble, got.bus_nibble);
            compare_field("hold_ms",    want.hold_ms,    got.hold_ms);
            compare_field("last_phase", want.last_phase, got.last_phase);
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_ready;
    logic [1:0] i_action     = ACT_INIT;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_cursor_row = 1'b0;
    logic [5:0] i_cursor_col = 6'd0;
    logic       o_valid;
    logic       i_ready      = 1'b0;
    logic       o_reg_select;
    logic       o_enable_pin;
    logic [3:0] o_bus_nibble;
    logic [7:0] o_hold_ms;
    logic       o_last_phase;
    logic       i_cfg_valid  = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index  = CFG_ENABLE_PULSE;
    logic [7:0] i_cfg_data   = 8'h00;

    // Set for the closing stretch: both sides run flat out
    bit quiet_tail = 1'b0;
    int idle_cycles = 0;

    lcd_pin_scoreboard sb = new();

    char_lcd_4bit_interface dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_cursor_row (i_cursor_row),
        .i_cursor_col (i_cursor_col),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_reg_select (o_reg_select),
        .o_enable_pin (o_enable_pin),
        .o_bus_nibble (o_bus_nibble),
        .o_hold_ms    (o_hold_ms),
        .o_last_phase (o_last_phase),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check every phase taken by the receiver, oldest prediction first
    always @(posedge i_clk) begin
        t_pin_phase got;
        if (i_rst_n && o_valid && i_ready) begin
            got.reg_select = o_reg_select;
            got.enable_pin = o_enable_pin;
            got.bus_nibble = o_bus_nibble;
            got.hold_ms    = o_hold_ms;
            got.last_phase = o_last_phase;
            sb.check_phase(got);
        end
    end

    // Watchdog: end the run once no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("** char_lcd_4bit_interface: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: mix stall bursts, short ready runs and long unbroken ready stretches
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (quiet_tail) begin
                i_ready <= 1'b1;
                @(negedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_ready <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(negedge i_clk);
                    end
                    1: begin
                        i_ready <= 1'b1;
                        repeat ($urandom_range(30, 80)) @(negedge i_clk);
                    end
                    default: begin
                        i_ready <= 1'b1;
                        repeat ($urandom_range(1, 8)) @(negedge i_clk);
                    end
                endcase
            end
        end
    end

    // Present one request and hold it until taken; valid stays high on return
    task automatic send_request(t_action act, logic [7:0] value, logic row, logic [5:0] col);
        i_valid      <= 1'b1;
        i_action     <= act;
        i_byte_value <= value;
        i_cursor_row <= row;
        i_cursor_col <= col;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(act, value, row, col);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every predicted phase has come out
    task automatic drain_phases();
        i_valid <= 1'b0;
        while (sb.pending_phases.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timing_reg(t_cfg_index idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_timing_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_timing(logic [7:0] pulse, logic [7:0] settle, logic [7:0] powerup);
        write_timing_reg(CFG_ENABLE_PULSE, pulse);
        write_timing_reg(CFG_COMMAND_SETTLE, settle);
        write_timing_reg(CFG_POWERUP_WAIT, powerup);
        // unmapped index must leave all timing untouched
        write_timing_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    endtask

    // Random requests; init is rarer since it costs 25 phases
    task automatic random_requests(int count);
        t_action act;
        logic [5:0] col;
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      act = ACT_INIT;
            else if (pick <= 3) act = ACT_CMD;
            else if (pick <= 6) act = ACT_DATA;
            else                act = ACT_CURSOR;
            // mostly on-screen columns, some past the row end
            col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                              : 6'($urandom_range(0, 39));
            if (!quiet_tail) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain_phases();
                end else if ($urandom_range(0, 3) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                end
            end
            send_request(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col);
        end
    endtask

    initial begin
        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset timing, every action, field extremes, ignored fields
        send_request(ACT_INIT,   8'h00, 1'b0, 6'd0);
        send_request(ACT_CMD,    8'h00, 1'b1, 6'd63);
        send_request(ACT_CMD,    8'hFF, 1'b0, 6'd0);
        send_request(ACT_DATA,   8'h00, 1'b0, 6'd0);
        send_request(ACT_DATA,   8'hFF, 1'b1, 6'd63);
        send_request(ACT_DATA,   8'h5A, 1'b0, 6'd21);
        send_request(ACT_CURSOR, 8'hFF, 1'b0, 6'd0);
        send_request(ACT_CURSOR, 8'h00, 1'b1, 6'd39);
        send_request(ACT_CURSOR, 8'hA5, 1'b0, 6'd40);
        send_request(ACT_CURSOR, 8'h5A, 1'b1, 6'd63);
        send_request(ACT_CURSOR, 8'h00, 1'b0, 6'd63);
        send_request(ACT_DATA,   8'hA5, 1'b0, 6'd0);
        // init right after data: power-up phase must show RS high and the old nibble
        send_request(ACT_INIT,   8'hFF, 1'b1, 6'd63);
        send_request(ACT_CMD,    8'h01, 1'b0, 6'd0);
        send_request(ACT_DATA,   8'h3C, 1'b1, 6'd42);
        drain_phases();

        // Smallest timing
        load_timing(8'h00, 8'h00, 8'h00);
        send_request(ACT_INIT, 8'h00, 1'b0, 6'd0);
        random_requests(100);
        drain_phases();

        // Largest timing; upper data bits on the 4-bit registers must be dropped
        load_timing(8'hFF, 8'hFF, 8'hFF);
        send_request(ACT_INIT, 8'h00, 1'b0, 6'd0);
        random_requests(105);
        drain_phases();

        load_timing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        random_requests(110);
        drain_phases();

        // Closing stretch at full rate on both sides
        load_timing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        quiet_tail = 1'b1;
        random_requests(125);
        drain_phases();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending_phases.size() == 0) begin
            $display("** char_lcd_4bit_interface: PASSED **");
        end else begin
            $display("** char_lcd_4bit_interface: FAILED **");
        end
        $finish;
    end

endmodule

@@ char_lcd_4bit_interface.f @@
design/lcd4_pkg.sv
design/lcd4_ctrl.sv
design/lcd4_datapath.sv
design/char_lcd_4bit_interface.sv
bench/char_lcd_4bit_interface_tb.sv
